[rtl/core/gha_pkg.sv]
// Shared types and constants for the generational handle allocator.
// Request and response payloads, queue entry and the epoch step function.
// No dependencies.
`timescale 1ns / 1ps

package gha_pkg;

    localparam logic [15:0] EPOCH_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] handle_in;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] handle_out;
        logic [5:0]  slot_index;
        logic [15:0] slot_epoch;
    } rsp_t;

    // Classified request as it sits in the queue
    typedef struct packed {
        op_t         op;
        logic [31:0] handle;
        logic        hit;      // handle nonzero and index inside the pool
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

    typedef struct packed {
        logic [15:0] wrap;
        logic [15:0] uniq;
    } epoch_t;

    // Step the wrap epoch; past the top it restarts at one and bumps the unique count
    function automatic epoch_t epoch_step(input epoch_t e);
        epoch_t r;
        if (e.wrap >= EPOCH_MAX) begin
            r.wrap = 16'd1;
            r.uniq = e.uniq + 16'd1;
        end
        else begin
            r.wrap = e.wrap + 16'd1;
            r.uniq = e.uniq;
        end
        return r;
    endfunction

endpackage

[rtl/core/generational_handle_allocator.sv]
// Generational handle allocator: a slot pool in BLOCKS blocks with next-fit
// search, each allocation stamped with a wrapping 16-bit epoch. Every request
// (allocate, free, look-up) takes two steps in the back-end sequencer: pop it
// from the queue and pick the lowest block with a free slot or issue the slot
// table read, then run the next-fit search or the handle compare and commit
// the result, and only then pop the next one. A two-entry queue and an output
// register keep the input side moving while a result waits. Used bits clear
// and block counters reset to the block size, so no clearing pass is needed.
// Depends on gha_pkg, gha_front, gha_back, gha_ram.
`timescale 1ns / 1ps

module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int SLOTS_PER_BLOCK = 32,
    parameter int BLOCKS          = 2,
    parameter int INDEX_BITS      = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int TOTAL = BLOCKS * SLOTS_PER_BLOCK;
    localparam int AW    = $clog2(TOTAL);

    queue_head_t   head;
    logic          pop;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [47:0]   ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [47:0]   ram_rd_data;

    gha_front #(
        .TOTAL_SLOTS (TOTAL),
        .INDEX_BITS  (INDEX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .pop       (pop),
        .head      (head)
    );

    gha_back #(
        .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
        .BLOCKS          (BLOCKS),
        .INDEX_BITS      (INDEX_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

    // slot table: stored handle in the upper 32 bits, unique count below
    gha_ram #(
        .WIDTH (48),
        .DEPTH (TOTAL)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

[rtl/core/gha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gha_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/gha_front.sv]
// Front end: accepts requests, decodes the action, checks the handle range
// and holds classified requests in a two-entry queue. Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_front
    import gha_pkg::*;
#(
    parameter int TOTAL_SLOTS = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    input  logic        pop,
    output queue_head_t head
);

    entry_t      entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    entry_t      cls;
    logic [31:0] idx;
    logic        push;
    logic        do_pop;

    always_comb
    begin
        idx = 32'(req.handle_in[INDEX_BITS-1:0]);
        case (req.action)
            OP_ALLOC:  cls.op = OP_ALLOC;
            OP_FREE:   cls.op = OP_FREE;
            OP_LOOKUP: cls.op = OP_LOOKUP;
            default:   cls.op = OP_NOP;
        endcase
        cls.handle = req.handle_in;
        cls.hit    = (req.handle_in != 32'd0) && (idx < 32'(TOTAL_SLOTS));
    end

    assign req_stall  = (count_reg == 2'd2);
    assign push       = req_valid && !req_stall;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/core/gha_back.sv]
// Back end: two-step sequencer that runs allocate, free and look-up against
// the used bits, block counters and the slot table RAM. Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_back
    import gha_pkg::*;
#(
    parameter int SLOTS_PER_BLOCK = 32,
    parameter int BLOCKS          = 2,
    parameter int INDEX_BITS      = 16,
    localparam int TOTAL = BLOCKS * SLOTS_PER_BLOCK,
    localparam int AW    = $clog2(TOTAL)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  queue_head_t   head,
    output logic          pop,
    output logic          ram_wr_en,
    output logic [AW-1:0] ram_wr_addr,
    output logic [47:0]   ram_wr_data,
    output logic          ram_rd_en,
    output logic [AW-1:0] ram_rd_addr,
    input  logic [47:0]   ram_rd_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rsp_t          rsp
);

    localparam int S  = SLOTS_PER_BLOCK;
    localparam int PW = $clog2(S);
    localparam int BW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CW = $clog2(S + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                        state_reg;
    op_t                           op_reg;
    logic [31:0]                   handle_reg;
    logic                          hit_reg;
    logic                          found_reg;
    logic [BW-1:0]                 blk_reg;
    logic [PW-1:0]                 pos_reg;
    logic [BLOCKS-1:0][S-1:0]      used_reg;
    logic [BLOCKS-1:0][CW-1:0]     cnt_reg;
    logic [BLOCKS-1:0][PW-1:0]     next_reg;
    epoch_t                        epoch_reg;
    logic                          rsp_valid_reg;
    rsp_t                          rsp_reg;

    // pop-side decode
    logic [AW-1:0] q_g;
    logic [BW-1:0] sel_blk;
    logic          sel_found;
    logic [BW-1:0] idx_blk;
    logic [PW-1:0] idx_pos;

    // execute-side logic
    logic [S-1:0]  uvec;
    logic [PW-1:0] nxt;
    logic          hi_found;
    logic [PW-1:0] hi_pos;
    logic          any_found;
    logic [PW-1:0] any_pos;
    logic          wrap;
    logic [PW-1:0] pick_pos;
    logic          pick_ok;
    logic          at_end;
    logic [PW-1:0] nxt_new;
    epoch_t        ep1;
    epoch_t        ep2;
    logic [AW-1:0] cur_g;
    logic [47:0]   h48;
    logic [31:0]   new_handle;
    logic          match;
    logic          rsp_free;
    logic          commit;
    rsp_t          res;

    always_comb
    begin
        q_g       = AW'(32'(head.entry.handle[INDEX_BITS-1:0]));
        sel_blk   = '0;
        sel_found = 1'b0;
        for (int b = BLOCKS - 1; b >= 0; b--)
        begin
            if (cnt_reg[b] != '0)
            begin
                sel_blk   = BW'(b);
                sel_found = 1'b1;
            end
        end
        idx_blk = '0;
        for (int b = 1; b < BLOCKS; b++)
        begin
            if (32'(q_g) >= 32'(b * S))
            begin
                idx_blk = BW'(b);
            end
        end
        idx_pos = PW'(32'(q_g) - 32'(idx_blk) * 32'(S));
    end

    assign pop         = (state_reg == ST_IDLE) && head.valid;
    assign ram_rd_en   = pop;
    assign ram_rd_addr = q_g;

    // Next-fit search: first free slot at or above the pointer, else the lowest one
    always_comb
    begin
        uvec      = used_reg[blk_reg];
        nxt       = next_reg[blk_reg];
        hi_found  = 1'b0;
        hi_pos    = '0;
        any_found = 1'b0;
        any_pos   = '0;
        for (int i = S - 1; i >= 0; i--)
        begin
            if (!uvec[i])
            begin
                any_found = 1'b1;
                any_pos   = PW'(i);
                if (32'(i) >= 32'(nxt))
                begin
                    hi_found = 1'b1;
                    hi_pos   = PW'(i);
                end
            end
        end
        wrap     = !hi_found;
        pick_pos = wrap ? any_pos : hi_pos;
        pick_ok  = found_reg && any_found;
        ep1      = wrap ? epoch_step(epoch_reg) : epoch_reg;
        at_end   = (32'(pick_pos) == 32'(S - 1));
        nxt_new  = at_end ? '0 : PW'(32'(pick_pos) + 32'd1);
        ep2      = at_end ? epoch_step(ep1) : ep1;
    end

    always_comb
    begin
        cur_g = (op_reg == OP_ALLOC)
              ? AW'(32'(blk_reg) * 32'(S) + 32'(pick_pos))
              : AW'(32'(blk_reg) * 32'(S) + 32'(pos_reg));
        h48   = (48'(ep1.wrap) << INDEX_BITS)
              | (48'(cur_g) & ((48'd1 << INDEX_BITS) - 48'd1));
        new_handle = h48[31:0];
        match = hit_reg && used_reg[blk_reg][pos_reg]
              && (ram_rd_data[47:16] == handle_reg);

        res = '0;
        case (op_reg)
            OP_ALLOC:
            begin
                if (pick_ok)
                begin
                    res.ok         = 1'b1;
                    res.handle_out = new_handle;
                    res.slot_index = 6'(32'(cur_g));
                    res.slot_epoch = ep1.uniq;
                end
            end
            OP_FREE, OP_LOOKUP:
            begin
                if (match)
                begin
                    res.ok         = 1'b1;
                    res.slot_index = 6'(32'(cur_g));
                    res.slot_epoch = ram_rd_data[15:0];
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    assign rsp_free    = !rsp_valid_reg || !rsp_stall;
    assign commit      = (state_reg == ST_EXEC) && rsp_free;
    assign ram_wr_en   = commit && (op_reg == OP_ALLOC) && pick_ok;
    assign ram_wr_addr = cur_g;
    assign ram_wr_data = {new_handle, ep1.uniq};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg     <= head.entry.op;
            handle_reg <= head.entry.handle;
            hit_reg    <= head.entry.hit;
            found_reg  <= sel_found;
            pos_reg    <= idx_pos;
            blk_reg    <= (head.entry.op == OP_ALLOC) ? sel_blk : idx_blk;
        end
        if (commit)
        begin
            rsp_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            next_reg      <= '0;
            for (int b = 0; b < BLOCKS; b++)
            begin
                cnt_reg[b] <= CW'(S);
            end
            epoch_reg     <= '{wrap: 16'd1, uniq: 16'd0};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg <= ST_IDLE;
                        if ((op_reg == OP_ALLOC) && pick_ok)
                        begin
                            used_reg[blk_reg][pick_pos] <= 1'b1;
                            cnt_reg[blk_reg]            <= cnt_reg[blk_reg] - CW'(1);
                            next_reg[blk_reg]           <= nxt_new;
                            epoch_reg                   <= ep2;
                        end
                        if ((op_reg == OP_FREE) && match)
                        begin
                            used_reg[blk_reg][pos_reg] <= 1'b0;
                            cnt_reg[blk_reg]           <= cnt_reg[blk_reg] + CW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // hold the result until it is taken
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[dv/generational_handle_allocator_test.sv]
// Self-checking testbench for generational_handle_allocator: a directed table, then phased
// random allocate/free/look-up traffic checked against an in-bench slot pool predictor.
// Depends on gha_pkg and the generational_handle_allocator top level.
`timescale 1ns / 1ps

module generational_handle_allocator_test;
    import gha_pkg::*;

    localparam int SPB          = 32;
    localparam int NBLK         = 2;
    localparam int POOL         = SPB * NBLK;
    localparam int RANDOM_ITEMS = 1730;
    localparam int MAX_SHOWN    = 10;
    localparam int TAIL_CYCLES  = 16;

    typedef enum int {
        MIX_CHURN,
        MIX_FILL,
        MIX_DRAIN
    } mix_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] handle;
        logic        typed;
        rsp_t        want;
    } dir_row_t;

    localparam rsp_t MISS = '0;

    // Rows with typed = 1 carry the response read straight off the behavior after reset
    localparam dir_row_t DIRECTED [0:20] = '{
        '{OP_LOOKUP, 32'h0001_0000, 1'b1, MISS},
        '{OP_ALLOC,  32'h0000_0000, 1'b1, {1'b1, 32'h0001_0000, 6'd0, 16'd0}},
        '{OP_ALLOC,  32'h0000_0000, 1'b1, {1'b1, 32'h0001_0001, 6'd1, 16'd0}},
        '{OP_LOOKUP, 32'h0001_0000, 1'b1, {1'b1, 32'h0000_0000, 6'd0, 16'd0}},
        '{OP_LOOKUP, 32'h0000_0000, 1'b1, MISS},
        '{OP_FREE,   32'h0000_0000, 1'b1, MISS},
        '{OP_LOOKUP, 32'h0001_0040, 1'b1, MISS},
        '{OP_FREE,   32'hFFFF_FFFF, 1'b1, MISS},
        '{OP_FREE,   32'h0002_0001, 1'b1, MISS},
        '{OP_NOP,    32'h0001_0000, 1'b1, MISS},
        '{OP_FREE,   32'h0001_0000, 1'b1, {1'b1, 32'h0000_0000, 6'd0, 16'd0}},
        '{OP_FREE,   32'h0001_0000, 1'b1, MISS},
        '{OP_LOOKUP, 32'h0001_0001, 1'b1, {1'b1, 32'h0000_0000, 6'd1, 16'd0}},
        '{OP_ALLOC,  32'h0000_0000, 1'b1, {1'b1, 32'h0001_0002, 6'd2, 16'd0}},
        '{OP_FREE,   32'hFFFF_0001, 1'b1, MISS},
        '{OP_LOOKUP, 32'h0001_003F, 1'b1, MISS},
        '{OP_ALLOC,  32'h0000_0000, 1'b0, MISS},
        '{OP_LOOKUP, 32'h0001_0003, 1'b0, MISS},
        '{OP_FREE,   32'h0001_0001, 1'b0, MISS},
        '{OP_FREE,   32'h0001_0002, 1'b0, MISS},
        '{OP_ALLOC,  32'hFFFF_FFFF, 1'b0, MISS}
    };

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    generational_handle_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Predicted slot pool
    logic        slot_busy [POOL];
    logic [31:0] slot_tag  [POOL];
    logic [15:0] slot_uniq [POOL];
    int          free_left [NBLK];
    int          next_pos  [NBLK];
    logic [15:0] wrap_ep;
    logic [15:0] uniq_ctr;

    rsp_t        pending_rsp [$];
    logic [31:0] live_handles [$];
    logic [31:0] retired_handles [$];
    rsp_t        head_rsp;

    int  errors;
    int  n_sent;
    int  n_alloc_ok;
    int  n_pool_full;
    int  n_free_ok;
    int  n_lookup_ok;
    int  n_miss;
    bit  calm_send;
    bit  calm_recv;
    int  stall_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d responses outstanding", pending_rsp.size());
        $display("generational_handle_allocator_test NOT OK");
        $finish;
    end

    function automatic void bump_epoch();
        if (wrap_ep == 16'hFFFF) begin
            wrap_ep  = 16'd1;
            uniq_ctr = uniq_ctr + 16'd1;
        end
        else begin
            wrap_ep = wrap_ep + 16'd1;
        end
    endfunction

    function automatic int step_pos(input int p);
        int n;
        n = p + 1;
        if (n >= SPB) begin
            n = 0;
            bump_epoch();
        end
        return n;
    endfunction

    // Apply one request to the predicted pool and return its response
    function automatic rsp_t pool_apply(input req_t r);
        rsp_t        o;
        int          b;
        int          pos;
        int          tries;
        int          g;
        bit          found;
        logic [15:0] idx;
        o = '0;
        case (r.action)
            OP_ALLOC: begin
                b = 0;
                while (b < NBLK && free_left[b] == 0)
                    b++;
                if (b < NBLK) begin
                    pos   = next_pos[b] % SPB;
                    found = 1'b0;
                    tries = 0;
                    while (!found && tries < SPB) begin
                        if (!slot_busy[b * SPB + pos])
                            found = 1'b1;
                        else begin
                            pos = step_pos(pos);
                            tries++;
                        end
                    end
                    if (found) begin
                        g            = b * SPB + pos;
                        slot_busy[g] = 1'b1;
                        slot_tag[g]  = {wrap_ep, 16'(g)};
                        slot_uniq[g] = uniq_ctr;
                        free_left[b]--;
                        next_pos[b]  = step_pos(pos);
                        o.ok         = 1'b1;
                        o.handle_out = slot_tag[g];
                        o.slot_index = 6'(g);
                        o.slot_epoch = slot_uniq[g];
                    end
                end
            end
            OP_FREE, OP_LOOKUP: begin
                idx = r.handle_in[15:0];
                if (r.handle_in != 32'd0 && idx < POOL) begin
                    if (slot_busy[idx] && slot_tag[idx] == r.handle_in) begin
                        o.ok         = 1'b1;
                        o.slot_index = idx[5:0];
                        o.slot_epoch = slot_uniq[idx];
                        if (r.action == OP_FREE) begin
                            slot_busy[idx] = 1'b0;
                            slot_tag[idx]  = 32'd0;
                            free_left[idx / SPB]++;
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t random_request(input mix_t mix);
        req_t r;
        int   roll;
        int   w_alloc;
        int   w_free;
        int   w_look;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                w_alloc = 75;
                w_free  = 0;
                w_look  = 10;
            end
            MIX_DRAIN: begin
                w_alloc = 10;
                w_free  = 60;
                w_look  = 15;
            end
            default: begin
                w_alloc = 35;
                w_free  = 30;
                w_look  = 15;
            end
        endcase
        r.handle_in = $urandom();
        r.action    = OP_ALLOC;
        if (roll < w_alloc) begin
            r.action = OP_ALLOC;
        end
        else if (roll < w_alloc + w_free + w_look) begin
            if (live_handles.size() > 0) begin
                r.action    = (roll < w_alloc + w_free) ? OP_FREE : OP_LOOKUP;
                r.handle_in = live_handles[$urandom_range(0, live_handles.size() - 1)];
            end
        end
        else begin
            r.action = $urandom_range(0, 1) ? OP_FREE : OP_LOOKUP;
            case ($urandom_range(0, 4))
                0: begin
                    if (retired_handles.size() > 0)
                        r.handle_in =
                            retired_handles[$urandom_range(0, retired_handles.size() - 1)];
                end
                1: begin
                    // Flip one bit of a live handle
                    if (live_handles.size() > 0)
                        r.handle_in = live_handles[$urandom_range(0, live_handles.size() - 1)]
                                      ^ (32'd1 << $urandom_range(0, 31));
                end
                2: r.action = 2'($urandom_range(0, 3));
                3: r.handle_in = {16'($urandom()), 16'($urandom_range(POOL, 65535))};
                default: begin
                    r.handle_in = 32'd0;
                    if ($urandom_range(0, 2) == 0)
                        r.action = OP_NOP;
                end
            endcase
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Present one request, hold it until the transfer, then predict; returns at a falling edge
    task automatic send_request(input req_t item, input bit typed, input rsp_t want);
        int   gap;
        rsp_t got;
        gap = 0;
        if (!calm_send && $urandom_range(0, 1) == 0)
            gap = idle_len();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        got = pool_apply(item);
        pending_rsp.push_back(typed ? want : got);
        n_sent++;
        if (item.action == OP_ALLOC) begin
            if (got.ok) begin
                n_alloc_ok++;
                live_handles.push_back(got.handle_out);
            end
            else
                n_pool_full++;
        end
        else if (got.ok && item.action == OP_FREE) begin
            n_free_ok++;
            for (int i = 0; i < live_handles.size(); i++) begin
                if (live_handles[i] == item.handle_in) begin
                    live_handles.delete(i);
                    break;
                end
            end
            retired_handles.push_back(item.handle_in);
            if (retired_handles.size() > 32)
                void'(retired_handles.pop_front());
        end
        else if (got.ok)
            n_lookup_ok++;
        else
            n_miss++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every response has been returned
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        rsp_stall  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else begin
                rsp_stall <= 1'b0;
                if (!calm_recv && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                flag_error($sformatf("response with nothing pending: ok %0b handle %h",
                                     rsp.ok, rsp.handle_out));
            end
            else begin
                head_rsp = pending_rsp.pop_front();
                if (rsp.ok !== head_rsp.ok || rsp.handle_out !== head_rsp.handle_out ||
                    rsp.slot_index !== head_rsp.slot_index ||
                    rsp.slot_epoch !== head_rsp.slot_epoch)
                    flag_error($sformatf(
                        "mismatch: ok %0b/%0b handle %h/%h slot %0d/%0d epoch %0d/%0d (exp/act)",
                        head_rsp.ok, rsp.ok, head_rsp.handle_out, rsp.handle_out,
                        head_rsp.slot_index, rsp.slot_index,
                        head_rsp.slot_epoch, rsp.slot_epoch));
            end
        end
    end

    initial begin
        mix_t mix;
        int   phase_len;
        int   phases;
        int   sent;
        req_t item;

        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        errors      = 0;
        n_sent      = 0;
        n_alloc_ok  = 0;
        n_pool_full = 0;
        n_free_ok   = 0;
        n_lookup_ok = 0;
        n_miss      = 0;
        calm_send   = 1'b0;
        calm_recv   = 1'b0;
        for (int i = 0; i < POOL; i++) begin
            slot_busy[i] = 1'b0;
            slot_tag[i]  = 32'd0;
            slot_uniq[i] = 16'd0;
        end
        for (int b = 0; b < NBLK; b++) begin
            free_left[b] = SPB;
            next_pos[b]  = 0;
        end
        wrap_ep  = 16'd1;
        uniq_ctr = 16'd0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i]) begin
            item.action    = DIRECTED[i].action;
            item.handle_in = DIRECTED[i].handle;
            send_request(item, DIRECTED[i].typed, DIRECTED[i].want);
        end
        settle();

        // Random traffic in phases; the first one uses the fill mix, mostly allocations
        sent   = 0;
        phases = 0;
        while (sent < RANDOM_ITEMS) begin
            mix       = (phases == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
            phase_len = $urandom_range(60, 160);
            calm_send = ($urandom_range(0, 3) == 0);
            calm_recv = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                send_request(random_request(mix), 1'b0, MISS);
                sent++;
            end
            phases++;
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
            flag_error($sformatf("%0d responses never arrived", pending_rsp.size()));
        $display("covered %0d requests in %0d random phases: %0d allocations, %0d refused full",
                 n_sent, phases, n_alloc_ok, n_pool_full);
        $display("%0d frees and %0d look-ups hit, %0d misses, wrap epoch now %0d; %0d errors",
                 n_free_ok, n_lookup_ok, n_miss, wrap_ep, errors);
        if (errors == 0)
            $display("generational_handle_allocator_test OK");
        else
            $display("generational_handle_allocator_test NOT OK");
        $finish;
    end

endmodule

[sim.f]
rtl/core/gha_pkg.sv
rtl/core/gha_ram.sv
rtl/core/gha_front.sv
rtl/core/gha_back.sv
rtl/core/generational_handle_allocator.sv
dv/generational_handle_allocator_test.sv
